@@ hw/rtl/assert_macros.svh @@
// assertion helpers included by the controller rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is asserted
`define PFD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked implication check, masked while reset is asserted
`define PFD_ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

`endif

@@ hw/rtl/pfd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfd_pkg
// Shared widths, reset values, register indexes and config type of the
// fan duty pid loop.
// ----------------------------------------------------------------------------
package pfd_pkg;

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    localparam int SAMPLE_BITS = 10;
    localparam int ACC_BITS    = 32;
    localparam int FRAC_BITS   = 8;
    localparam int HEIGHT_W    = 10;
    localparam int GAIN_W      = 16;
    localparam int INV_W       = 10;
    localparam int DUTY_W      = 10;
    localparam int DUTY_MAX    = 1023;

    // error and sample difference
    localparam int ERR_W     = max_int(HEIGHT_W, SAMPLE_BITS) + 1;
    // difference times inverse period
    localparam int D1_W      = ERR_W + INV_W;
    localparam int MUL_A_W   = max_int(ACC_BITS, D1_W);
    localparam int MUL_B_W   = GAIN_W;
    localparam int PROD_W    = MUL_A_W + MUL_B_W + 1;
    localparam int ACC_SUM_W = max_int(ACC_BITS, ERR_W + GAIN_W + 1) + 1;
    localparam int SUM_W     = PROD_W + 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HEIGHT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_INTEG    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DERIV    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_RATE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_PERIOD    = 3'd5;

    localparam logic [HEIGHT_W-1:0]    TARGET_RESET  = 10'd500;
    localparam logic [GAIN_W-1:0]      GAIN_P_RESET  = 16'd317;
    localparam logic [GAIN_W-1:0]      GAIN_I_RESET  = 16'd128;
    localparam logic [GAIN_W-1:0]      GAIN_D_RESET  = 16'd26;
    localparam logic [GAIN_W-1:0]      RATE_RESET    = 16'd8;
    localparam logic [INV_W-1:0]       INV_PER_RESET = 10'd10;
    localparam logic [SAMPLE_BITS-1:0] PREV_RESET    = SAMPLE_BITS'(30);

    typedef struct packed {
        logic [HEIGHT_W-1:0] target_height;
        logic [GAIN_W-1:0]   gain_prop;
        logic [GAIN_W-1:0]   gain_integ;
        logic [GAIN_W-1:0]   gain_deriv;
        logic [GAIN_W-1:0]   integ_rate;
        logic [INV_W-1:0]    inv_period;
    } pfd_cfg_t;

endpackage

@@ hw/rtl/pfd_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfd_if
// Valid/ready channels for height samples in and duty results out.
// ----------------------------------------------------------------------------
interface pfd_sample_if import pfd_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] height_sample;

    modport source (output valid, output height_sample, input ready);
    modport sink   (input valid, input height_sample, output ready);
endinterface

interface pfd_duty_if import pfd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] duty_value;
    logic              clamped_low;
    logic              clamped_high;

    modport source (output valid, output duty_value, output clamped_low,
                    output clamped_high, input ready);
    modport sink   (input valid, input duty_value, input clamped_low,
                    input clamped_high, output ready);
endinterface

@@ hw/rtl/pfd_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfd_cfg
// Setpoint, gain and period registers behind a plain write port.
// ----------------------------------------------------------------------------
module pfd_cfg import pfd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output pfd_cfg_t              cfg
);

    pfd_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_height <= TARGET_RESET;
            cfg_reg.gain_prop     <= GAIN_P_RESET;
            cfg_reg.gain_integ    <= GAIN_I_RESET;
            cfg_reg.gain_deriv    <= GAIN_D_RESET;
            cfg_reg.integ_rate    <= RATE_RESET;
            cfg_reg.inv_period    <= INV_PER_RESET;
        end
        else if (wr_en)
        begin
            case (index)
                CFG_TARGET_HEIGHT: cfg_reg.target_height <= wr_data[HEIGHT_W-1:0];
                CFG_GAIN_PROP:     cfg_reg.gain_prop     <= wr_data[GAIN_W-1:0];
                CFG_GAIN_INTEG:    cfg_reg.gain_integ    <= wr_data[GAIN_W-1:0];
                CFG_GAIN_DERIV:    cfg_reg.gain_deriv    <= wr_data[GAIN_W-1:0];
                CFG_INTEG_RATE:    cfg_reg.integ_rate    <= wr_data[GAIN_W-1:0];
                CFG_INV_PERIOD:    cfg_reg.inv_period    <= wr_data[INV_W-1:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hw/rtl/pfd_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfd_mul
// Shared signed-by-unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module pfd_mul import pfd_pkg::*;
(
    input  logic                      clk,
    input  logic signed [MUL_A_W-1:0] op_a,
    input  logic        [MUL_B_W-1:0] op_b,
    output logic signed [PROD_W-1:0]  prod
);

    logic signed [MUL_B_W:0]  op_b_s;
    logic signed [PROD_W-1:0] prod_reg;

    // unsigned operand gets a zero sign bit
    assign op_b_s = $signed({1'b0, op_b});

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b_s;
    end

    assign prod = prod_reg;

endmodule

@@ hw/rtl/pid_fan_duty_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_fan_duty_controller
// Discrete pid loop turning a height sample into a clamped fan pwm duty.
// ----------------------------------------------------------------------------
// Each height sample transfer yields one duty transfer. The sample is taken
// when the sequencer is idle; the five products (integral step, proportional,
// derivative difference step, integral term, derivative gain step) go one per
// cycle through a single registered multiplier before the sum is clamped and
// registered, and a new sample is taken only after the sequencer returns to
// idle. The next sample can be taken while a finished duty still waits on the
// output register. Gains are unsigned Q8.8, the integral saturates at the
// signed accumulator range, and the duty is clamped to 0..1023 with flags for
// either clamp.
module pid_fan_duty_controller import pfd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    pfd_sample_if.sink            sample,
    pfd_duty_if.source            duty
);

`include "assert_macros.svh"

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_M_IR,
        ST_M_P,
        ST_M_DI,
        ST_M_I,
        ST_M_DG,
        ST_D_ADD,
        ST_FIN
    } state_t;

    localparam logic signed [ACC_SUM_W-1:0] ACC_HI =
        ACC_SUM_W'((64'sd1 <<< (ACC_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_SUM_W-1:0] ACC_LO = ~ACC_HI;
    localparam logic signed [PROD_W-1:0] PROD_BIAS = PROD_W'((1 << FRAC_BITS) - 1);
    localparam logic signed [PROD_W-1:0] PROD_ZERO = '0;
    localparam logic signed [SUM_W-1:0]  SUM_BIAS  = SUM_W'((1 << FRAC_BITS) - 1);
    localparam logic signed [SUM_W-1:0]  SUM_ZERO  = '0;
    localparam logic signed [SUM_W-1:0]  DUTY_LIM  = SUM_W'(DUTY_MAX);

    pfd_cfg_t cfg;

    state_t                    state_reg, state_next;
    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic signed [ERR_W-1:0]   diff_reg, diff_next;
    logic [SAMPLE_BITS-1:0]    prev_reg, prev_next;
    logic signed [ACC_BITS-1:0] accum_reg, accum_next;
    logic signed [D1_W-1:0]    d1_reg, d1_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic [DUTY_W-1:0]         duty_reg, duty_next;
    logic                      lo_reg, lo_next;
    logic                      hi_reg, hi_next;
    logic                      out_valid_reg, out_valid_next;

    logic signed [MUL_A_W-1:0]   op_a;
    logic        [MUL_B_W-1:0]   op_b;
    logic signed [PROD_W-1:0]    prod;
    logic signed [ACC_SUM_W-1:0] acc_sum;
    logic signed [ACC_BITS-1:0]  acc_sat;
    logic signed [PROD_W-1:0]    i_biased;
    logic signed [PROD_W-1:0]    i_term;
    logic signed [SUM_W-1:0]     sum_biased;
    logic signed [SUM_W-1:0]     raw;

    pfd_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cfg_wr_en),
        .index   (cfg_index),
        .wr_data (cfg_wr_data),
        .cfg     (cfg)
    );

    pfd_mul u_mul
    (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    // operand select for the shared multiplier
    always_comb
    begin
        op_a = MUL_A_W'(err_reg);
        op_b = cfg.integ_rate;
        case (state_reg)
            ST_M_IR:
            begin
                op_a = MUL_A_W'(err_reg);
                op_b = cfg.integ_rate;
            end
            ST_M_P:
            begin
                op_a = MUL_A_W'(err_reg);
                op_b = cfg.gain_prop;
            end
            ST_M_DI:
            begin
                op_a = MUL_A_W'(diff_reg);
                op_b = MUL_B_W'(cfg.inv_period);
            end
            ST_M_I:
            begin
                op_a = MUL_A_W'(accum_reg);
                op_b = cfg.gain_integ;
            end
            ST_M_DG:
            begin
                op_a = MUL_A_W'(d1_reg);
                op_b = cfg.gain_deriv;
            end
            default:
            begin
                op_a = MUL_A_W'(err_reg);
                op_b = cfg.integ_rate;
            end
        endcase
    end

    // integral update with saturation
    always_comb
    begin
        acc_sum = ACC_SUM_W'(accum_reg) + ACC_SUM_W'(prod);
        if (acc_sum > ACC_HI)
            acc_sat = ACC_BITS'(ACC_HI);
        else if (acc_sum < ACC_LO)
            acc_sat = ACC_BITS'(ACC_LO);
        else
            acc_sat = ACC_BITS'(acc_sum);
    end

    // divide by 256 toward zero: bias negatives before the arithmetic shift
    always_comb
    begin
        i_biased   = prod + (prod[PROD_W-1] ? PROD_BIAS : PROD_ZERO);
        i_term     = i_biased >>> FRAC_BITS;
        sum_biased = sum_reg + (sum_reg[SUM_W-1] ? SUM_BIAS : SUM_ZERO);
        raw        = sum_biased >>> FRAC_BITS;
    end

    always_comb
    begin
        state_next     = state_reg;
        err_next       = err_reg;
        diff_next      = diff_reg;
        prev_next      = prev_reg;
        accum_next     = accum_reg;
        d1_next        = d1_reg;
        sum_next       = sum_reg;
        duty_next      = duty_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        out_valid_next = out_valid_reg;

        if (duty.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (sample.valid)
                begin
                    err_next   = $signed(ERR_W'(cfg.target_height)
                                         - ERR_W'(sample.height_sample));
                    diff_next  = $signed(ERR_W'(sample.height_sample) - ERR_W'(prev_reg));
                    prev_next  = sample.height_sample;
                    state_next = ST_M_IR;
                end
            end
            ST_M_IR:
            begin
                state_next = ST_M_P;
            end
            ST_M_P:
            begin
                accum_next = acc_sat;
                state_next = ST_M_DI;
            end
            ST_M_DI:
            begin
                // proportional term opens the sum
                sum_next   = SUM_W'(prod);
                state_next = ST_M_I;
            end
            ST_M_I:
            begin
                d1_next    = $signed(prod[D1_W-1:0]);
                state_next = ST_M_DG;
            end
            ST_M_DG:
            begin
                sum_next   = sum_reg + SUM_W'(i_term);
                state_next = ST_D_ADD;
            end
            ST_D_ADD:
            begin
                sum_next   = sum_reg + SUM_W'(prod);
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // hold here until the output register is free
                if (!out_valid_reg || duty.ready)
                begin
                    if (raw[SUM_W-1])
                    begin
                        duty_next = '0;
                        lo_next   = 1'b1;
                        hi_next   = 1'b0;
                    end
                    else if (raw > DUTY_LIM)
                    begin
                        duty_next = DUTY_W'(DUTY_MAX);
                        lo_next   = 1'b0;
                        hi_next   = 1'b1;
                    end
                    else
                    begin
                        duty_next = raw[DUTY_W-1:0];
                        lo_next   = 1'b0;
                        hi_next   = 1'b0;
                    end
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            prev_reg      <= PREV_RESET;
            accum_reg     <= '0;
            out_valid_reg <= 1'b0;
            duty_reg      <= '0;
            lo_reg        <= 1'b0;
            hi_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_reg      <= prev_next;
            accum_reg     <= accum_next;
            out_valid_reg <= out_valid_next;
            duty_reg      <= duty_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg  <= err_next;
        diff_reg <= diff_next;
        d1_reg   <= d1_next;
        sum_reg  <= sum_next;
    end

    assign sample.ready      = (state_reg == ST_IDLE);
    assign duty.valid        = out_valid_reg;
    assign duty.duty_value   = duty_reg;
    assign duty.clamped_low  = lo_reg;
    assign duty.clamped_high = hi_reg;

    `PFD_ASSERT(a_start_seq, (sample.valid && sample.ready) |=> (state_reg == ST_M_IR), "sample transfer did not start the sequence")
    `PFD_ASSERT_IMPL(a_one_clamp, duty.valid, !(duty.clamped_low && duty.clamped_high), "both clamp flags set")
    `PFD_ASSERT_IMPL(a_low_zero, duty.valid && duty.clamped_low, duty.duty_value == '0, "low clamp with nonzero duty")
    `PFD_ASSERT_IMPL(a_high_max, duty.valid && duty.clamped_high, duty.duty_value == DUTY_W'(DUTY_MAX), "high clamp below full duty")

endmodule

@@ tb/pid_fan_duty_controller_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_fan_duty_controller_test
// Self-checking bench for the fan duty pid loop. Height samples go in over a
// valid/ready channel while a local pid predictor keeps its own setpoint,
// gains, integral and previous sample; every duty transfer is compared
// with the oldest predicted duty and clamp flags. Directed checks cover reset
// values, register extremes, masking, spare indexes and truncation near zero;
// random phases vary the settings, drive the integral into both saturation
// limits and stall the output long enough to back up the input.
// ----------------------------------------------------------------------------
module pid_fan_duty_controller_test;
    import pfd_pkg::*;

    localparam int           TIMEOUT_CYCLES = 600000;
    localparam int           DRAIN_CYCLES   = 16;
    localparam longint       ACC_HI         = (longint'(1) <<< (ACC_BITS - 1)) - 1;
    localparam longint       ACC_LO         = -ACC_HI - 1;
    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_value;
        logic              clamped_low;
        logic              clamped_high;
    } duty_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;

    pfd_sample_if sample_ch ();
    pfd_duty_if   duty_ch ();

    pid_fan_duty_controller dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .sample      (sample_ch),
        .duty        (duty_ch)
    );

    // predictor state
    pfd_cfg_t               loop_cfg;
    longint                 integ_acc;
    logic [SAMPLE_BITS-1:0] last_height;

    duty_result_t expected_duty_q[$];
    int           mismatch_count = 0;
    int           cycle_count    = 0;
    bit           tx_idle_en     = 1'b1;
    bit           rx_idle_en     = 1'b1;
    int           rx_hold_left   = 0;
    int           rx_gap_left    = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < TIMEOUT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("pid_fan_duty_controller verification failed");
        $finish;
    end

    function automatic duty_result_t predict_duty(input logic [SAMPLE_BITS-1:0] h);
        longint       err;
        longint       p_term;
        longint       i_term;
        longint       d_term;
        longint       raw;
        duty_result_t r;
        err = longint'(loop_cfg.target_height) - longint'(h);
        integ_acc = integ_acc + longint'(loop_cfg.integ_rate) * err;
        if (integ_acc > ACC_HI)
            integ_acc = ACC_HI;
        else if (integ_acc < ACC_LO)
            integ_acc = ACC_LO;
        p_term = longint'(loop_cfg.gain_prop) * err;
        // signed division truncates toward zero
        i_term = (longint'(loop_cfg.gain_integ) * integ_acc) / 256;
        d_term = longint'(loop_cfg.gain_deriv)
                 * ((longint'(h) - longint'(last_height)) * longint'(loop_cfg.inv_period));
        raw = (p_term + i_term + d_term) / 256;
        r = '0;
        if (raw < 0)
            r.clamped_low = 1'b1;
        else if (raw > DUTY_MAX)
        begin
            r.duty_value   = DUTY_W'(DUTY_MAX);
            r.clamped_high = 1'b1;
        end
        else
            r.duty_value = DUTY_W'(raw);
        last_height = h;
        return r;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_gain(input int typical_max);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return CFG_DATA_W'($urandom_range(0, typical_max));
        endcase
    endfunction

    // write enable stays high across back-to-back writes, send_height drops it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        case (idx)
            CFG_TARGET_HEIGHT: loop_cfg.target_height = data[HEIGHT_W-1:0];
            CFG_GAIN_PROP:     loop_cfg.gain_prop     = data[GAIN_W-1:0];
            CFG_GAIN_INTEG:    loop_cfg.gain_integ    = data[GAIN_W-1:0];
            CFG_GAIN_DERIV:    loop_cfg.gain_deriv    = data[GAIN_W-1:0];
            CFG_INTEG_RATE:    loop_cfg.integ_rate    = data[GAIN_W-1:0];
            CFG_INV_PERIOD:    loop_cfg.inv_period    = data[INV_W-1:0];
            default:           ;
        endcase
        @(negedge clk);
    endtask

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_height(input logic [SAMPLE_BITS-1:0] h);
        cfg_wr_en <= 1'b0;
        if (tx_idle_en && $urandom_range(0, 3) == 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        sample_ch.valid         <= 1'b1;
        sample_ch.height_sample <= h;
        do
            @(posedge clk);
        while (sample_ch.ready !== 1'b1);
        expected_duty_q.push_back(predict_duty(h));
        @(negedge clk);
    endtask

    task automatic settle_idle();
        sample_ch.valid <= 1'b0;
        while (expected_duty_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // receiver: random stall bursts plus an optional long hold
    initial
    begin
        duty_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                duty_ch.ready <= 1'b0;
            end
            else if (rx_gap_left > 0)
            begin
                rx_gap_left--;
                duty_ch.ready <= 1'b0;
            end
            else if (rx_idle_en && $urandom_range(0, 7) == 0)
            begin
                rx_gap_left = $urandom_range(1, 17) - 1;
                duty_ch.ready <= 1'b0;
            end
            else
                duty_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        duty_result_t exp_r;
        if (rst_n && duty_ch.valid === 1'b1 && duty_ch.ready === 1'b1)
        begin
            if (expected_duty_q.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected duty transfer, expected none, got duty=%0d low=%b high=%b",
                         $time, duty_ch.duty_value, duty_ch.clamped_low,
                         duty_ch.clamped_high);
            end
            else
            begin
                exp_r = expected_duty_q.pop_front();
                if (duty_ch.duty_value !== exp_r.duty_value
                    || duty_ch.clamped_low !== exp_r.clamped_low
                    || duty_ch.clamped_high !== exp_r.clamped_high)
                begin
                    mismatch_count++;
                    $display("%0t: duty mismatch expected duty=%0d low=%b high=%b, got duty=%0d low=%b high=%b",
                             $time, exp_r.duty_value, exp_r.clamped_low,
                             exp_r.clamped_high, duty_ch.duty_value,
                             duty_ch.clamped_low, duty_ch.clamped_high);
                end
            end
        end
    end

    task automatic test_reset_defaults();
        send_height('0);
        send_height('1);
        send_height(SAMPLE_BITS'(500));
        send_height(SAMPLE_BITS'(30));
        send_height(SAMPLE_BITS'(500));
    endtask

    task automatic test_register_extremes();
        settle_idle();
        write_reg(CFG_TARGET_HEIGHT, '0);
        write_reg(CFG_GAIN_PROP, '1);
        write_reg(CFG_GAIN_INTEG, '1);
        write_reg(CFG_GAIN_DERIV, '1);
        write_reg(CFG_INTEG_RATE, '1);
        write_reg(CFG_INV_PERIOD, CFG_DATA_W'(1023));
        send_height('1);
        settle_idle();
        // opposite error cancels the integral step of the previous sample
        write_reg(CFG_TARGET_HEIGHT, CFG_DATA_W'(1023));
        send_height('0);
        settle_idle();
        // zero inverse period kills the derivative term
        write_reg(CFG_GAIN_PROP, '0);
        write_reg(CFG_GAIN_INTEG, '0);
        write_reg(CFG_INTEG_RATE, '0);
        write_reg(CFG_INV_PERIOD, '0);
        send_height('1);
        send_height('0);
        settle_idle();
        write_reg(CFG_GAIN_PROP, CFG_DATA_W'(256));
        write_reg(CFG_INV_PERIOD, CFG_DATA_W'(1));
        send_height(SAMPLE_BITS'(700));
        send_height(SAMPLE_BITS'(200));
    endtask

    task automatic test_register_masking();
        settle_idle();
        write_reg(CFG_TARGET_HEIGHT, 16'hFC20);
        write_reg(CFG_INV_PERIOD, 16'hFC05);
        write_reg(CFG_GAIN_DERIV, CFG_DATA_W'(300));
        send_height(SAMPLE_BITS'(10));
        send_height(SAMPLE_BITS'(40));
    endtask

    task automatic test_spare_index();
        settle_idle();
        write_reg(CFG_SPARE_LO, 16'h1234);
        write_reg(CFG_SPARE_HI, '1);
        send_height(SAMPLE_BITS'(40));
        send_height(SAMPLE_BITS'(90));
    endtask

    task automatic test_small_negative_sum();
        settle_idle();
        write_reg(CFG_GAIN_DERIV, '0);
        write_reg(CFG_TARGET_HEIGHT, CFG_DATA_W'(500));
        write_reg(CFG_GAIN_PROP, CFG_DATA_W'(255));
        // sum of -255 truncates to zero, no low clamp
        send_height(SAMPLE_BITS'(501));
        send_height(SAMPLE_BITS'(499));
        settle_idle();
        write_reg(CFG_GAIN_PROP, CFG_DATA_W'(256));
        send_height(SAMPLE_BITS'(501));
    endtask

    task automatic test_random_traffic(input int phases, input int per_phase);
        int v;
        for (int p = 0; p < phases; p++)
        begin
            settle_idle();
            write_reg(CFG_TARGET_HEIGHT, CFG_DATA_W'($urandom()));
            write_reg(CFG_GAIN_PROP, random_gain(1024));
            write_reg(CFG_GAIN_INTEG, ($urandom_range(0, 2) == 0) ? '0 : random_gain(64));
            write_reg(CFG_GAIN_DERIV, random_gain(64));
            write_reg(CFG_INTEG_RATE, random_gain(32));
            write_reg(CFG_INV_PERIOD, ($urandom_range(0, 9) == 0)
                                      ? CFG_DATA_W'($urandom_range(0, 15))
                                      : CFG_DATA_W'($urandom()));
            for (int i = 0; i < per_phase; i++)
            begin
                if ($urandom_range(0, 3) == 0)
                    v = $urandom_range(0, 1023);
                else
                begin
                    v = int'(loop_cfg.target_height) + $urandom_range(0, 80) - 40;
                    if (v < 0)
                        v = 0;
                    else if (v > 1023)
                        v = 1023;
                end
                send_height(SAMPLE_BITS'(v));
            end
        end
    endtask

    task automatic test_integral_saturation();
        settle_idle();
        write_reg(CFG_GAIN_PROP, '0);
        write_reg(CFG_GAIN_DERIV, '0);
        write_reg(CFG_GAIN_INTEG, CFG_DATA_W'(1));
        write_reg(CFG_INTEG_RATE, '1);
        write_reg(CFG_TARGET_HEIGHT, CFG_DATA_W'(1023));
        repeat (45) send_height(SAMPLE_BITS'($urandom_range(0, 63)));
        settle_idle();
        write_reg(CFG_GAIN_INTEG, '1);
        write_reg(CFG_TARGET_HEIGHT, '0);
        repeat (80) send_height(SAMPLE_BITS'($urandom_range(960, 1023)));
    endtask

    task automatic test_output_backpressure();
        settle_idle();
        write_reg(CFG_TARGET_HEIGHT, CFG_DATA_W'(512));
        write_reg(CFG_GAIN_PROP, CFG_DATA_W'(400));
        write_reg(CFG_GAIN_INTEG, '0);
        write_reg(CFG_GAIN_DERIV, CFG_DATA_W'(8));
        write_reg(CFG_INTEG_RATE, CFG_DATA_W'(4));
        write_reg(CFG_INV_PERIOD, CFG_DATA_W'(10));
        tx_idle_en   = 1'b0;
        rx_hold_left = 250;
        repeat (30) send_height(SAMPLE_BITS'($urandom_range(300, 700)));
        tx_idle_en = 1'b1;
    endtask

    initial
    begin
        rst_n                   = 1'b0;
        cfg_wr_en               = 1'b0;
        cfg_index               = '0;
        cfg_wr_data             = '0;
        sample_ch.valid         = 1'b0;
        sample_ch.height_sample = '0;
        loop_cfg = '{target_height: TARGET_RESET, gain_prop: GAIN_P_RESET,
                     gain_integ: GAIN_I_RESET, gain_deriv: GAIN_D_RESET,
                     integ_rate: RATE_RESET, inv_period: INV_PER_RESET};
        integ_acc   = 0;
        last_height = PREV_RESET;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_register_extremes();
        test_register_masking();
        test_spare_index();
        test_small_negative_sum();
        test_random_traffic(16, 100);
        test_integral_saturation();
        test_output_backpressure();
        // last stretch runs at full rate on both sides
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        test_random_traffic(2, 60);

        settle_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("pid_fan_duty_controller verification clean");
        else
            $display("pid_fan_duty_controller verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/pfd_pkg.sv
hw/rtl/pfd_if.sv
hw/rtl/pfd_cfg.sv
hw/rtl/pfd_mul.sv
hw/rtl/pid_fan_duty_controller.sv
tb/pid_fan_duty_controller_test.sv
